>>> sv/gra_pkg.sv
// Shared types and codes of the grid rectangle allocator.
package gra_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [1:0] CMD_PLACE_FIRST = 2'd0;
  localparam logic [1:0] CMD_PLACE_AT    = 2'd1;
  localparam logic [1:0] CMD_REMOVE      = 2'd2;
  localparam logic [1:0] CMD_QUERY       = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW     = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] item_id;
    logic [3:0] item_width;
    logic [3:0] item_height;
    logic [3:0] cell_column;
    logic [5:0] cell_row;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] placed_column;
    logic [5:0] placed_row;
    logic [6:0] rows_now;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_BEGIN,
    S_FF_START,
    S_CHK_RD,
    S_CHK_CK,
    S_FILL,
    S_FAIL,
    S_RM_RD,
    S_RM_CK,
    S_DONE
  } gra_state_e;

endpackage

>>> sv/gra_if.sv
// Valid/ready channel carrying one item.
interface gra_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/gra_ram.sv
// Cell owner memory: one write port, one registered read port.
module gra_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gra_ctrl.sv
// Sequencer: config registers, clearing pass, first-fit search, fill and remove.
module gra_ctrl
  import gra_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS   = 16,
  parameter int unsigned MAX_ROWS      = 64,
  parameter int unsigned MAX_ITEM_SIDE = 8,
  parameter int unsigned AW            = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  item_t                 item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [7:0]            ram_wdata_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [7:0]            ram_rdata_i
);

  // coordinate width: holds request plus size and any bound
  localparam int unsigned NW = $clog2(MAX_ROWS + MAX_COLUMNS + 2 * MAX_ITEM_SIDE + 80) + 1;
  localparam int unsigned RESET_ROWS = (MAX_ROWS < 8) ? MAX_ROWS : 8;
  localparam int unsigned RESET_COLS = 16;

  gra_state_e    state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [7:0]    id_q, id_d;
  logic [NW-1:0] w_q, w_d, h_q, h_d, rc_q, rc_d, rr_q, rr_d;
  logic [NW-1:0] c_q, c_d, r_q, r_d, x_q, x_d, y_q, y_d;
  logic          at_q, at_d;
  logic [1:0]    status_q, status_d;
  logic [NW-1:0] rows_q, rows_d;
  logic [4:0]    cols_q, cols_d;
  logic          vert_q, vert_d, grow_q, grow_d;
  logic [NW-1:0] sw_cols_q, sw_cols_d, sw_rows_q, sw_rows_d;
  logic [NW-1:0] sr_q, sr_d, sc_q, sc_d;

  logic [NW-1:0] cols_eff, cell_r, cell_c, in_w, in_h, new_cols, new_rows;
  logic [AW-1:0] cell_addr, sweep_addr;
  logic          last_cell;

  always_comb begin
    if (cols_q == 5'd0) cols_eff = NW'(1);
    else if (32'(cols_q) > MAX_COLUMNS) cols_eff = NW'(MAX_COLUMNS);
    else cols_eff = NW'(cols_q);

    if (item_i.item_width == 4'd0) in_w = NW'(1);
    else if (32'(item_i.item_width) > MAX_ITEM_SIDE) in_w = NW'(MAX_ITEM_SIDE);
    else in_w = NW'(item_i.item_width);
    if (item_i.item_height == 4'd0) in_h = NW'(1);
    else if (32'(item_i.item_height) > MAX_ITEM_SIDE) in_h = NW'(MAX_ITEM_SIDE);
    else in_h = NW'(item_i.item_height);

    if (cfg_data_i[4:0] == 5'd0) new_cols = NW'(1);
    else if (32'(cfg_data_i[4:0]) > MAX_COLUMNS) new_cols = NW'(MAX_COLUMNS);
    else new_cols = NW'(cfg_data_i[4:0]);
    if (cfg_data_i == '0) new_rows = NW'(1);
    else if (32'(cfg_data_i) > MAX_ROWS) new_rows = NW'(MAX_ROWS);
    else new_rows = NW'(cfg_data_i);
  end

  // shared address unit
  assign cell_r     = r_q + y_q;
  assign cell_c     = c_q + x_q;
  assign cell_addr  = AW'(32'(cell_r) * 32'(MAX_COLUMNS) + 32'(cell_c));
  assign sweep_addr = AW'(32'(sr_q) * 32'(MAX_COLUMNS) + 32'(sc_q));
  assign last_cell  = (y_q + NW'(1) == h_q) && (x_q + NW'(1) == w_q);

  always_comb begin
    state_d = state_q;   cmd_d = cmd_q;     id_d = id_q;
    w_d = w_q;  h_d = h_q;  rc_d = rc_q;  rr_d = rr_q;
    c_d = c_q;  r_d = r_q;  x_d = x_q;    y_d = y_q;
    at_d = at_q;  status_d = status_q;
    rows_d = rows_q;  cols_d = cols_q;  vert_d = vert_q;  grow_d = grow_q;
    sw_cols_d = sw_cols_q;  sw_rows_d = sw_rows_q;  sr_d = sr_q;  sc_d = sc_q;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = cell_addr;
    ram_wdata_o  = 8'd0;
    ram_raddr_o  = cell_addr;

    case (state_q)
      S_IDLE: begin
        item_ready_o = !cfg_we_i;
        if (item_valid_i && !cfg_we_i) begin
          cmd_d = item_i.command;
          id_d  = item_i.item_id;
          w_d   = vert_q ? in_h : in_w;
          h_d   = vert_q ? in_w : in_h;
          rc_d  = NW'(item_i.cell_column);
          rr_d  = NW'(item_i.cell_row);
          state_d = S_BEGIN;
        end
      end
      S_SWEEP: begin
        ram_we_o    = (sr_q >= sw_rows_q) || (sc_q >= sw_cols_q);
        ram_waddr_o = sweep_addr;
        if (sc_q == NW'(MAX_COLUMNS - 1)) begin
          sc_d = '0;
          sr_d = sr_q + NW'(1);
          if (sr_q == NW'(MAX_ROWS - 1)) state_d = S_IDLE;
        end else begin
          sc_d = sc_q + NW'(1);
        end
      end
      S_BEGIN: begin
        x_d = '0;
        y_d = '0;
        at_d = 1'b0;
        case (cmd_q)
          CMD_PLACE_AT: begin
            if ((rc_q + w_q <= cols_eff) && (rr_q + h_q <= rows_q)) begin
              c_d = rc_q;
              r_d = rr_q;
              at_d = 1'b1;
              state_d = S_CHK_RD;
            end else begin
              state_d = S_FF_START;
            end
          end
          CMD_REMOVE: begin
            c_d = '0;
            r_d = '0;
            if (id_q == 8'd0) begin
              status_d = STATUS_NOT_FOUND;
              state_d = S_DONE;
            end else begin
              state_d = S_RM_RD;
            end
          end
          default: state_d = S_FF_START;
        endcase
      end
      S_FF_START: begin
        at_d = 1'b0;
        c_d = '0;  r_d = '0;  x_d = '0;  y_d = '0;
        if ((h_q > rows_q) || (w_q > cols_eff)) state_d = S_FAIL;
        else state_d = S_CHK_RD;
      end
      S_CHK_RD: state_d = S_CHK_CK;
      S_CHK_CK: begin
        if (ram_rdata_i != 8'd0) begin
          x_d = '0;
          y_d = '0;
          if (at_q) begin
            state_d = S_FF_START;
          end else if (c_q + NW'(1) + w_q <= cols_eff) begin
            c_d = c_q + NW'(1);
            state_d = S_CHK_RD;
          end else if (r_q + NW'(1) + h_q <= rows_q) begin
            c_d = '0;
            r_d = r_q + NW'(1);
            state_d = S_CHK_RD;
          end else begin
            state_d = S_FAIL;
          end
        end else if (last_cell) begin
          x_d = '0;
          y_d = '0;
          if (cmd_q == CMD_QUERY) begin
            status_d = STATUS_OK;
            state_d = S_DONE;
          end else begin
            state_d = S_FILL;
          end
        end else begin
          if (y_q + NW'(1) < h_q) y_d = y_q + NW'(1);
          else begin
            y_d = '0;
            x_d = x_q + NW'(1);
          end
          state_d = S_CHK_RD;
        end
      end
      S_FILL: begin
        ram_we_o    = (cell_c < cols_eff) && (cell_r < rows_q);
        ram_wdata_o = (cmd_q == CMD_REMOVE) ? 8'd0 : id_q;
        if (last_cell) begin
          status_d = STATUS_OK;
          state_d = S_DONE;
        end else if (y_q + NW'(1) < h_q) begin
          y_d = y_q + NW'(1);
        end else begin
          y_d = '0;
          x_d = x_q + NW'(1);
        end
      end
      S_FAIL: begin
        if ((cmd_q != CMD_QUERY) && grow_q && (rows_q < NW'(MAX_ROWS))) begin
          rows_d = rows_q + NW'(1);
          state_d = S_FF_START;
        end else begin
          status_d = STATUS_NO_ROOM;
          c_d = '0;
          r_d = '0;
          state_d = S_DONE;
        end
      end
      S_RM_RD: state_d = S_RM_CK;
      S_RM_CK: begin
        if (ram_rdata_i == id_q) begin
          state_d = S_FILL;
        end else if (r_q + NW'(1) < rows_q) begin
          r_d = r_q + NW'(1);
          state_d = S_RM_RD;
        end else if (c_q + NW'(1) < cols_eff) begin
          r_d = '0;
          c_d = c_q + NW'(1);
          state_d = S_RM_RD;
        end else begin
          status_d = STATUS_NOT_FOUND;
          c_d = '0;
          r_d = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // config writes; a pending clearing pass keeps the smaller area
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: begin
          cols_d = cfg_data_i[4:0];
          sw_cols_d = ((state_q == S_SWEEP) && (sw_cols_q < new_cols)) ? sw_cols_q : new_cols;
          sw_rows_d = (state_q == S_SWEEP) ? sw_rows_q : rows_q;
          sr_d = '0;
          sc_d = '0;
          state_d = S_SWEEP;
        end
        CFG_ROWS: begin
          rows_d = new_rows;
          sw_rows_d = ((state_q == S_SWEEP) && (sw_rows_q < new_rows)) ? sw_rows_q : new_rows;
          sw_cols_d = (state_q == S_SWEEP) ? sw_cols_q : cols_eff;
          sr_d = '0;
          sc_d = '0;
          state_d = S_SWEEP;
        end
        CFG_VERTICAL: vert_d = cfg_data_i[0];
        CFG_GROW:     grow_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      rows_q    <= NW'(RESET_ROWS);
      cols_q    <= 5'(RESET_COLS);
      vert_q    <= 1'b0;
      grow_q    <= 1'b0;
      sw_cols_q <= '0;
      sw_rows_q <= '0;
      sr_q      <= '0;
      sc_q      <= '0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      vert_q    <= vert_d;
      grow_q    <= grow_d;
      sw_cols_q <= sw_cols_d;
      sw_rows_q <= sw_rows_d;
      sr_q      <= sr_d;
      sc_q      <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  id_q <= id_d;
    w_q <= w_d;  h_q <= h_d;  rc_q <= rc_d;  rr_q <= rr_d;
    c_q <= c_d;  r_q <= r_d;  x_q <= x_d;  y_q <= y_d;
    at_q <= at_d;  status_q <= status_d;
  end

  assign res_o.status        = status_q;
  assign res_o.placed_column = c_q[3:0];
  assign res_o.placed_row    = r_q[5:0];
  assign res_o.rows_now      = 7'(rows_q);

endmodule

>>> sv/grid_rectangle_first_fit_allocator.sv
// Top level of the first-fit grid rectangle allocator.
// Keeps a grid of cell owner ids in a MAX_COLUMNS x MAX_ROWS memory and runs one command at a
// time: place first free, place at cell (falling back to first fit), remove by id, query fit.
// A single sequencer walks the memory through one read port, with a read state and a check
// state for each cell checked; a fill writes the cells of the rectangle in turn, and a remove
// scans for the id before its clear. Each auto-grow step reruns the search. After reset, and
// after every write of grid_columns or initial_rows, a clearing pass over the MAX_COLUMNS x
// MAX_ROWS memory runs before the next item is taken; configuration writes are accepted during
// it. A finished result waits in an output register, so the next item is taken while it is
// unread.
module grid_rectangle_first_fit_allocator
  import gra_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS   = 16,
  parameter int unsigned MAX_ROWS      = 64,
  parameter int unsigned MAX_ITEM_SIDE = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gra_if.sink                   in_i,
  gra_if.source                 out_o
);

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          res_valid, res_ready;
  result_t       res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          out_valid_q;
  result_t       out_data_q;

  gra_ctrl #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_ITEM_SIDE(MAX_ITEM_SIDE),
    .AW           (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_valid_i(in_i.valid),
    .item_ready_o(in_i.ready),
    .item_i      (in_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  gra_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register: result holds here until taken
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_rows_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.rows_now != 7'd0)
    else $error("rows_now is zero");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.status != 2'd3)
    else $error("undefined status code");

  a_fail_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status != STATUS_OK) |->
      (out_o.data.placed_column == 4'd0 && out_o.data.placed_row == 6'd0))
    else $error("failed command reports nonzero position");

  a_no_item_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> !in_i.ready)
    else $error("item taken while a result is stalled");

endmodule
